// ===== design/skse_pkg.sv =====
package skse_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_REMOVE = 3'd1,
		FN_EXISTS = 3'd2,
		FN_MIN    = 3'd3,
		FN_MAX    = 3'd4,
		FN_PRED   = 3'd5,
		FN_SUCC   = 3'd6,
		FN_CLEAR  = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_MISS    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_NONEIGH = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	// what a cell does with its entry at the next edge
	typedef enum logic [1:0] {
		CMD_HOLD  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_LEFT  = 2'd2,
		CMD_RIGHT = 2'd3
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		key_t      key;
	} cell_ctl_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage

// ===== design/skse_req_if.sv =====
interface skse_req_if import skse_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic        take;
	key_t        key;

	modport source (output valid, func, take, key, input ready);
	modport sink   (input valid, func, take, key, output ready);
endinterface

// ===== design/skse_rsp_if.sv =====
interface skse_rsp_if import skse_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	key_t        value;
	cnt_t        count;

	modport source (output valid, status, value, count, input ready);
	modport sink   (input valid, status, value, count, output ready);
endinterface

// ===== design/sorted_key_set_engine.sv =====
// Channel | Dir | Fields                 | Accepted when
// req     | in  | func, take, key        | req.valid && req.ready
// rsp     | out | status, value, count   | rsp.valid && rsp.ready
//
// One request per cycle: all cells compare against the key in the accept
// cycle, the chain shifts at that same edge, and the result is registered.
// The result register is the only buffer; req.ready drops only while a result
// waits and rsp.ready is low. Reset clears the count and the result valid;
// cell contents are undefined until written and never read beyond the count.
module sorted_key_set_engine import skse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	skse_req_if.sink     req,
	skse_rsp_if.source   rsp
);

	// chain state and per-cell views
	key_t            cell_key  [CAPACITY];
	key_t            left_in   [CAPACITY];
	key_t            right_in  [CAPACITY];
	cell_ctl_t       cell_ctl  [CAPACITY];
	cell_flags_t     cell_flg  [CAPACITY];

	logic [CAPACITY-1:0] in_use;     // thermometer: entry below the count
	logic [CAPACITY-1:0] below;      // held and strictly less than key
	logic [CAPACITY-1:0] hit;        // held and equal to key
	logic [CAPACITY-1:0] below_prev; // below of the cell to the left
	logic [CAPACITY-1:0] m_max, m_pred, m_succ;
	logic [CAPACITY-1:0] sel_min, sel_max, sel_pred, sel_succ, sel;
	logic [CAPACITY-1:0] rm_mask;

	cnt_t    count_q;
	logic    rsp_valid_q;
	status_t rsp_status_q;
	key_t    rsp_value_q;
	cnt_t    rsp_count_q;

	logic    accept;
	logic    held, empty, full, found;
	logic    do_ins, do_rm;
	func_t   func;
	key_t    found_key;
	status_t status_d;
	key_t    value_d;
	cnt_t    count_d;

	assign func   = func_t'(req.func);
	assign accept = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;

	// build the chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_in[i] = req.key;
		end else begin : g_mid_l
			assign left_in[i] = cell_key[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_in[i] = cell_key[i];
		end else begin : g_mid_r
			assign right_in[i] = cell_key[i+1];
		end

		assign in_use[i] = CNT_W'(i) < count_q;
		assign below[i]  = in_use[i] && cell_flg[i].lt;
		assign hit[i]    = in_use[i] && cell_flg[i].eq;

		// insert: keep the lower part, drop the key at the first slot not below
		// it, move everything above one slot right; remove: shift masked cells left
		always_comb begin
			cell_ctl[i].key = req.key;
			cell_ctl[i].cmd = CMD_HOLD;
			if (accept && do_ins) begin
				if (below[i])
					cell_ctl[i].cmd = CMD_HOLD;
				else if (below_prev[i])
					cell_ctl[i].cmd = CMD_LOAD;
				else
					cell_ctl[i].cmd = CMD_LEFT;
			end else if (accept && do_rm && rm_mask[i]) begin
				cell_ctl[i].cmd = CMD_RIGHT;
			end
		end

		skse_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.left_key  (left_in[i]),
			.right_key (right_in[i]),
			.key       (cell_key[i]),
			.flags     (cell_flg[i])
		);
	end

	// neighbor views of the masks; all masks are thermometers, so one-hot
	// selects fall out of edge detection
	assign below_prev = {below[CAPACITY-2:0], 1'b1};
	assign m_max      = ~{1'b0, in_use[CAPACITY-1:1]};
	assign m_pred     = ~{1'b0, below[CAPACITY-1:1]};
	assign m_succ     = ~below & ~hit;

	assign sel_min  = {{(CAPACITY-1){1'b0}}, in_use[0]};
	assign sel_max  = in_use & m_max;
	assign sel_pred = below & m_pred;
	assign sel_succ = in_use & m_succ & ~{m_succ[CAPACITY-2:0], 1'b0};

	always_comb begin
		unique case (func)
			FN_MIN:  sel = sel_min;
			FN_MAX:  sel = sel_max;
			FN_PRED: sel = sel_pred;
			FN_SUCC: sel = sel_succ;
			default: sel = '0;
		endcase
	end

	always_comb begin
		found_key = '0;
		for (int i = 0; i < CAPACITY; i++)
			found_key = found_key | (cell_key[i] & {KEY_W{sel[i]}});
	end

	assign held  = |hit;
	assign found = |sel;
	assign empty = count_q == '0;
	assign full  = count_q == CNT_W'(CAPACITY);

	// decode the request
	always_comb begin
		status_d = ST_OK;
		value_d  = '0;
		count_d  = count_q;
		do_ins   = 1'b0;
		do_rm    = 1'b0;
		rm_mask  = '0;
		unique case (func)
			FN_INSERT: begin
				if (held)
					status_d = ST_MISS;
				else if (full)
					status_d = ST_FULL;
				else begin
					do_ins  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			FN_REMOVE: begin
				if (held) begin
					do_rm   = 1'b1;
					rm_mask = ~below;
					count_d = count_q - CNT_W'(1);
				end else
					status_d = ST_MISS;
			end
			FN_EXISTS: begin
				status_d = held ? ST_OK : ST_MISS;
			end
			FN_CLEAR: begin
				count_d = '0;
			end
			default: begin
				// min, max, neighbor lookups; optionally take the found key
				if (empty)
					status_d = ST_EMPTY;
				else if (!found)
					status_d = ST_NONEIGH;
				else begin
					value_d = found_key;
					if (req.take) begin
						do_rm   = 1'b1;
						count_d = count_q - CNT_W'(1);
						unique case (func)
							FN_MIN:  rm_mask = '1;
							FN_MAX:  rm_mask = m_max;
							FN_PRED: rm_mask = m_pred;
							default: rm_mask = m_succ;
						endcase
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the result payload until a new item is accepted
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_status_q <= status_d;
			rsp_value_q  <= value_d;
			rsp_count_q  <= count_d;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.value  = rsp_value_q;
	assign rsp.count  = rsp_count_q;

endmodule

// ===== design/skse_cell.sv =====
module skse_cell import skse_pkg::*; (
	input  logic        clk,
	input  cell_ctl_t   ctl,
	input  key_t        left_key,
	input  key_t        right_key,
	output key_t        key,
	output cell_flags_t flags
);

	key_t key_q;

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CMD_HOLD:  key_q <= key_q;
			CMD_LOAD:  key_q <= ctl.key;
			CMD_LEFT:  key_q <= left_key;
			CMD_RIGHT: key_q <= right_key;
			default:   key_q <= key_q;
		endcase
	end

	assign key      = key_q;
	assign flags.lt = key_q < ctl.key;
	assign flags.eq = key_q == ctl.key;

endmodule

// ===== design/skse_checker.sv =====
module skse_checker import skse_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_status,
	input key_t       rsp_value,
	input cnt_t       rsp_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_value) && $stable(rsp_count))
		else $error("result changed while stalled");

	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted item produced no result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= CNT_W'(CAPACITY))
		else $error("count beyond capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_count == CNT_W'(CAPACITY))
		else $error("full reported below capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0 && rsp_value == '0)
		else $error("empty reported with keys held");

endmodule

bind sorted_key_set_engine skse_checker u_skse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_value  (rsp.value),
	.rsp_count  (rsp.count)
);
